/* sv/lsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared widths, register indexes and the divider cell payload for the
// line segment intersection block.
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int COORD_W  = 32;
    localparam int ITEM_W   = 8 * COORD_W;
    localparam int DEN_W    = 66;   // |r x s| <= 2^65
    localparam int QUO_W    = 32;   // quotient bits produced by the cell row
    localparam int NUM_W    = 100;  // |a*den + r*nt| < 2^99
    localparam int PTOL_W   = 32;
    localparam int TOL_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_CELLS = QUO_W;

    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_TOL    = 2'd1;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    // one coordinate in flight through the divider row
    typedef struct packed {
        logic               neg;
        logic               big;    // quotient already known to exceed 32 bits
        logic [DEN_W-1:0]   rem;
        logic [QUO_W-1:0]   lq;     // low numerator bits out, quotient bits in
    } div_lane_t;

    typedef struct packed {
        logic               found;
        logic [DEN_W-1:0]   den;
        div_lane_t          x;
        div_lane_t          y;
    } cell_t;

endpackage
`default_nettype wire

/* sv/lsi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsi_front
// Pipelined front end: cross products, parallel and range tests, and the
// numerators of the intersection point, handed to the divider row.
// ----------------------------------------------------------------------------
module lsi_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [lsi_pkg::ITEM_W-1:0]          in_data,
    input  wire logic                                in_bounded,
    input  wire logic [lsi_pkg::PTOL_W-1:0]          parallel_tol,
    input  wire logic [lsi_pkg::TOL_W-1:0]           param_tol,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output lsi_pkg::cell_t                           out_cell
);

    logic [8:1] v_reg;
    logic [8:1] en;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[8] = !v_reg[8] || out_ready;
        for (int k = 7; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 8; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: differences
    logic signed [31:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    assign asx = in_data[31:0];
    assign asy = in_data[63:32];
    assign aex = in_data[95:64];
    assign aey = in_data[127:96];
    assign bsx = in_data[159:128];
    assign bsy = in_data[191:160];
    assign bex = in_data[223:192];
    assign bey = in_data[255:224];

    logic signed [32:0] s1_rx_reg, s1_ry_reg, s1_sx_reg, s1_sy_reg, s1_qx_reg, s1_qy_reg;
    logic signed [32:0] s1_rx_next, s1_ry_next, s1_sx_next, s1_sy_next, s1_qx_next, s1_qy_next;
    logic signed [31:0] s1_ax_reg, s1_ay_reg;
    logic               s1_bnd_reg;

    always_comb
    begin
        s1_rx_next = {aex[31], aex} - {asx[31], asx};
        s1_ry_next = {aey[31], aey} - {asy[31], asy};
        s1_sx_next = {bex[31], bex} - {bsx[31], bsx};
        s1_sy_next = {bey[31], bey} - {bsy[31], bsy};
        s1_qx_next = {bsx[31], bsx} - {asx[31], asx};
        s1_qy_next = {bsy[31], bsy} - {asy[31], asy};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_rx_reg  <= s1_rx_next;
            s1_ry_reg  <= s1_ry_next;
            s1_sx_reg  <= s1_sx_next;
            s1_sy_reg  <= s1_sy_next;
            s1_qx_reg  <= s1_qx_next;
            s1_qy_reg  <= s1_qy_next;
            s1_ax_reg  <= asx;
            s1_ay_reg  <= asy;
            s1_bnd_reg <= in_bounded;
        end
    end

    // stage 2: the six products of the cross terms
    logic signed [65:0] s2_p0_reg, s2_p1_reg, s2_p2_reg, s2_p3_reg, s2_p4_reg, s2_p5_reg;
    logic signed [65:0] s2_p0_next, s2_p1_next, s2_p2_next, s2_p3_next, s2_p4_next, s2_p5_next;
    logic signed [31:0] s2_ax_reg, s2_ay_reg;
    logic signed [32:0] s2_rx_reg, s2_ry_reg;
    logic               s2_bnd_reg;

    always_comb
    begin
        s2_p0_next = s1_rx_reg * s1_sy_reg;
        s2_p1_next = s1_ry_reg * s1_sx_reg;
        s2_p2_next = s1_qx_reg * s1_sy_reg;
        s2_p3_next = s1_qy_reg * s1_sx_reg;
        s2_p4_next = s1_qx_reg * s1_ry_reg;
        s2_p5_next = s1_qy_reg * s1_rx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_p0_reg  <= s2_p0_next;
            s2_p1_reg  <= s2_p1_next;
            s2_p2_reg  <= s2_p2_next;
            s2_p3_reg  <= s2_p3_next;
            s2_p4_reg  <= s2_p4_next;
            s2_p5_reg  <= s2_p5_next;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_rx_reg  <= s1_rx_reg;
            s2_ry_reg  <= s1_ry_reg;
            s2_bnd_reg <= s1_bnd_reg;
        end
    end

    // stage 3: cross products
    logic signed [66:0] s3_den_reg, s3_nt_reg, s3_nu_reg;
    logic signed [66:0] s3_den_next, s3_nt_next, s3_nu_next;
    logic signed [31:0] s3_ax_reg, s3_ay_reg;
    logic signed [32:0] s3_rx_reg, s3_ry_reg;
    logic               s3_bnd_reg;

    always_comb
    begin
        s3_den_next = 67'(s2_p0_reg) - 67'(s2_p1_reg);
        s3_nt_next  = 67'(s2_p2_reg) - 67'(s2_p3_reg);
        s3_nu_next  = 67'(s2_p4_reg) - 67'(s2_p5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_den_reg <= s3_den_next;
            s3_nt_reg  <= s3_nt_next;
            s3_nu_reg  <= s3_nu_next;
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_rx_reg  <= s2_rx_reg;
            s3_ry_reg  <= s2_ry_reg;
            s3_bnd_reg <= s2_bnd_reg;
        end
    end

    // stage 4: make the denominator positive, parallel test
    logic [65:0]        s4_d_reg, s4_d_next;
    logic signed [66:0] s4_nt_reg, s4_nu_reg, s4_nt_next, s4_nu_next;
    logic               s4_np_reg, s4_np_next;
    logic signed [66:0] den_neg;
    logic signed [31:0] s4_ax_reg, s4_ay_reg;
    logic signed [32:0] s4_rx_reg, s4_ry_reg;
    logic               s4_bnd_reg;

    always_comb
    begin
        den_neg    = -s3_den_reg;
        s4_d_next  = s3_den_reg[66] ? den_neg[65:0] : s3_den_reg[65:0];
        s4_nt_next = s3_den_reg[66] ? -s3_nt_reg : s3_nt_reg;
        s4_nu_next = s3_den_reg[66] ? -s3_nu_reg : s3_nu_reg;
        s4_np_next = s4_d_next > {34'd0, parallel_tol};
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_d_reg   <= s4_d_next;
            s4_nt_reg  <= s4_nt_next;
            s4_nu_reg  <= s4_nu_next;
            s4_np_reg  <= s4_np_next;
            s4_ax_reg  <= s3_ax_reg;
            s4_ay_reg  <= s3_ay_reg;
            s4_rx_reg  <= s3_rx_reg;
            s4_ry_reg  <= s3_ry_reg;
            s4_bnd_reg <= s3_bnd_reg;
        end
    end

    // stage 5: partial products, wide operands split at bit 34
    logic signed [34:0] d_lo;
    logic signed [32:0] d_hi;
    logic signed [34:0] nt_lo;
    logic signed [32:0] nt_hi;
    logic signed [16:0] tol_s;
    logic signed [66:0] s5_axl_reg, s5_ayl_reg, s5_axl_next, s5_ayl_next;
    logic signed [64:0] s5_axh_reg, s5_ayh_reg, s5_axh_next, s5_ayh_next;
    logic signed [67:0] s5_rxl_reg, s5_ryl_reg, s5_rxl_next, s5_ryl_next;
    logic signed [65:0] s5_rxh_reg, s5_ryh_reg, s5_rxh_next, s5_ryh_next;
    logic signed [51:0] s5_tl_reg, s5_tl_next;
    logic signed [49:0] s5_th_reg, s5_th_next;
    logic [65:0]        s5_d_reg;
    logic signed [66:0] s5_nt_reg, s5_nu_reg;
    logic               s5_np_reg, s5_bnd_reg;

    always_comb
    begin
        d_lo        = $signed({1'b0, s4_d_reg[33:0]});
        d_hi        = $signed({1'b0, s4_d_reg[65:34]});
        nt_lo       = $signed({1'b0, s4_nt_reg[33:0]});
        nt_hi       = s4_nt_reg[66:34];
        tol_s       = $signed({1'b0, param_tol});
        s5_axl_next = s4_ax_reg * d_lo;
        s5_axh_next = s4_ax_reg * d_hi;
        s5_ayl_next = s4_ay_reg * d_lo;
        s5_ayh_next = s4_ay_reg * d_hi;
        s5_rxl_next = s4_rx_reg * nt_lo;
        s5_rxh_next = s4_rx_reg * nt_hi;
        s5_ryl_next = s4_ry_reg * nt_lo;
        s5_ryh_next = s4_ry_reg * nt_hi;
        s5_tl_next  = tol_s * d_lo;
        s5_th_next  = tol_s * d_hi;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_axl_reg <= s5_axl_next;
            s5_axh_reg <= s5_axh_next;
            s5_ayl_reg <= s5_ayl_next;
            s5_ayh_reg <= s5_ayh_next;
            s5_rxl_reg <= s5_rxl_next;
            s5_rxh_reg <= s5_rxh_next;
            s5_ryl_reg <= s5_ryl_next;
            s5_ryh_reg <= s5_ryh_next;
            s5_tl_reg  <= s5_tl_next;
            s5_th_reg  <= s5_th_next;
            s5_d_reg   <= s4_d_reg;
            s5_nt_reg  <= s4_nt_reg;
            s5_nu_reg  <= s4_nu_reg;
            s5_np_reg  <= s4_np_reg;
            s5_bnd_reg <= s4_bnd_reg;
        end
    end

    // stage 6: point numerators and tolerance times denominator
    logic signed [100:0] s6_x_reg, s6_y_reg, s6_x_next, s6_y_next;
    logic signed [84:0]  s6_p_reg, s6_p_next;
    logic [65:0]         s6_d_reg;
    logic signed [66:0]  s6_nt_reg, s6_nu_reg;
    logic                s6_np_reg, s6_bnd_reg;

    always_comb
    begin
        s6_x_next = 101'(s5_axl_reg) + (101'(s5_axh_reg) <<< 34)
                  + 101'(s5_rxl_reg) + (101'(s5_rxh_reg) <<< 34);
        s6_y_next = 101'(s5_ayl_reg) + (101'(s5_ayh_reg) <<< 34)
                  + 101'(s5_ryl_reg) + (101'(s5_ryh_reg) <<< 34);
        s6_p_next = 85'(s5_tl_reg) + (85'(s5_th_reg) <<< 34);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_x_reg   <= s6_x_next;
            s6_y_reg   <= s6_y_next;
            s6_p_reg   <= s6_p_next;
            s6_d_reg   <= s5_d_reg;
            s6_nt_reg  <= s5_nt_reg;
            s6_nu_reg  <= s5_nu_reg;
            s6_np_reg  <= s5_np_reg;
            s6_bnd_reg <= s5_bnd_reg;
        end
    end

    // stage 7: range test, magnitudes of the numerators
    logic signed [84:0]  hi_s, lo_s, sct, scu;
    logic signed [100:0] x_neg, y_neg;
    logic                t_ok, u_ok;
    logic                s7_hit_reg, s7_hit_next;
    logic [99:0]         s7_nx_reg, s7_ny_reg, s7_nx_next, s7_ny_next;
    logic                s7_sx_reg, s7_sy_reg;
    logic [65:0]         s7_d_reg;

    always_comb
    begin
        lo_s        = -s6_p_reg;
        hi_s        = $signed({3'b000, s6_d_reg, 16'h0000}) + s6_p_reg;
        sct         = $signed({{2{s6_nt_reg[66]}}, s6_nt_reg, 16'h0000});
        scu         = $signed({{2{s6_nu_reg[66]}}, s6_nu_reg, 16'h0000});
        t_ok        = (sct >= lo_s) && (sct <= hi_s);
        u_ok        = (scu >= lo_s) && (scu <= hi_s);
        s7_hit_next = s6_np_reg && (!s6_bnd_reg || (t_ok && u_ok));
        x_neg       = -s6_x_reg;
        y_neg       = -s6_y_reg;
        s7_nx_next  = s6_x_reg[100] ? x_neg[99:0] : s6_x_reg[99:0];
        s7_ny_next  = s6_y_reg[100] ? y_neg[99:0] : s6_y_reg[99:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_hit_reg <= s7_hit_next;
            s7_nx_reg  <= s7_nx_next;
            s7_ny_reg  <= s7_ny_next;
            s7_sx_reg  <= s6_x_reg[100];
            s7_sy_reg  <= s6_y_reg[100];
            s7_d_reg   <= s6_d_reg;
        end
    end

    // stage 8: quotients of 2^32 or more are flagged here; every coordinate still goes to the row
    lsi_pkg::cell_t s8_cell_reg, s8_cell_next;

    always_comb
    begin
        s8_cell_next.found  = s7_hit_reg;
        s8_cell_next.den    = s7_d_reg;
        s8_cell_next.x.neg  = s7_sx_reg;
        s8_cell_next.x.big  = s7_nx_reg >= {2'b00, s7_d_reg, 32'h0};
        s8_cell_next.x.rem  = s7_nx_reg[97:32];
        s8_cell_next.x.lq   = s7_nx_reg[31:0];
        s8_cell_next.y.neg  = s7_sy_reg;
        s8_cell_next.y.big  = s7_ny_reg >= {2'b00, s7_d_reg, 32'h0};
        s8_cell_next.y.rem  = s7_ny_reg[97:32];
        s8_cell_next.y.lq   = s7_ny_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_cell_reg <= s8_cell_next;
        end
    end

    assign out_cell = s8_cell_reg;

endmodule
`default_nettype wire

/* sv/lsi_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsi_div_cell
// One restoring division step on both coordinates, registered, with its own
// valid and a ready that lets bubbles close up.
// ----------------------------------------------------------------------------
module lsi_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lsi_pkg::cell_t   in_cell,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lsi_pkg::cell_t        out_cell
);

    logic           valid_reg;
    lsi_pkg::cell_t cell_reg, cell_next;

    function automatic lsi_pkg::div_lane_t lane_step(lsi_pkg::div_lane_t l,
                                                     logic [lsi_pkg::DEN_W-1:0] d);
        logic [lsi_pkg::DEN_W:0] trial;
        logic [lsi_pkg::DEN_W:0] diff;
        logic                    ge;
        lsi_pkg::div_lane_t      r;
        trial = {l.rem, l.lq[lsi_pkg::QUO_W-1]};
        diff  = trial - {1'b0, d};
        ge    = trial >= {1'b0, d};
        r.neg = l.neg;
        r.big = l.big;
        r.rem = ge ? diff[lsi_pkg::DEN_W-1:0] : trial[lsi_pkg::DEN_W-1:0];
        r.lq  = {l.lq[lsi_pkg::QUO_W-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        cell_next       = in_cell;
        cell_next.x     = lane_step(in_cell.x, in_cell.den);
        cell_next.y     = lane_step(in_cell.y, in_cell.den);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule
`default_nettype wire

/* sv/line_segment_intersect_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_segment_intersect_top
// Intersection of two 2D lines or segments given by Q16.16 endpoints.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pair of lines per beat: eight coordinates in s_tdata and
//   the bounded flag in s_tuser. m_* returns one result beat per input beat,
//   in order: cross_x and cross_y in m_tdata, found and overflow in m_tuser.
//   cfg_* writes parallel_tol (index 0) or param_tol (index 1); cfg_ready is
//   always high, other indexes are dropped. Write only while the block is idle.
//   Between input and result, a beat passes 41 registers: eight front
//   stages (cross products, tests and numerators), a row of 32 division
//   cells giving one quotient bit each, and the output register.
//   One beat per cycle is taken unless the whole pipeline is full.
//   Every stage has its own valid, so bubbles close up when m_tready is low;
//   s_tready drops only once the whole pipeline is full. Reset clears all
//   valids and both registers to zero.
// ----------------------------------------------------------------------------
module line_segment_intersect_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [lsi_pkg::ITEM_W-1:0]         s_tdata,
    // bounded
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // cross_x, cross_y
    output logic [2*lsi_pkg::COORD_W-1:0]           m_tdata,
    // found, overflow
    output logic [1:0]                              m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lsi_pkg::PTOL_W-1:0]         cfg_data
);

    logic [lsi_pkg::PTOL_W-1:0] parallel_tol_reg;
    logic [lsi_pkg::TOL_W-1:0]  param_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parallel_tol_reg <= '0;
            param_tol_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lsi_pkg::REG_PARALLEL_TOL)
            begin
                parallel_tol_reg <= cfg_data;
            end
            if (cfg_index == lsi_pkg::REG_PARAM_TOL)
            begin
                param_tol_reg <= cfg_data[lsi_pkg::TOL_W-1:0];
            end
        end
    end

    logic           chain_valid [lsi_pkg::NUM_CELLS+1];
    logic           chain_ready [lsi_pkg::NUM_CELLS+1];
    lsi_pkg::cell_t chain_cell  [lsi_pkg::NUM_CELLS+1];

    lsi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata),
        .in_bounded   (s_tuser[0]),
        .parallel_tol (parallel_tol_reg),
        .param_tol    (param_tol_reg),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_cell     (chain_cell[0])
    );

    for (genvar i = 0; i < lsi_pkg::NUM_CELLS; i++)
    begin : g_cell
        lsi_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    // sign, saturation and output register
    lsi_pkg::cell_t              last;
    logic [lsi_pkg::COORD_W-1:0] qx, qy, vx, vy;
    logic                        satx, saty;
    logic                        out_valid_reg;
    logic [2*lsi_pkg::COORD_W-1:0] tdata_reg, tdata_next;
    logic [1:0]                  tuser_reg, tuser_next;
    logic                        out_en;

    assign last = chain_cell[lsi_pkg::NUM_CELLS];

    always_comb
    begin
        qx   = last.x.lq;
        qy   = last.y.lq;
        satx = last.x.big || (last.x.neg ? (qx > lsi_pkg::COORD_MIN) : qx[lsi_pkg::COORD_W-1]);
        saty = last.y.big || (last.y.neg ? (qy > lsi_pkg::COORD_MIN) : qy[lsi_pkg::COORD_W-1]);
        if (satx)
        begin
            vx = last.x.neg ? lsi_pkg::COORD_MIN : lsi_pkg::COORD_MAX;
        end
        else
        begin
            vx = last.x.neg ? -qx : qx;
        end
        if (saty)
        begin
            vy = last.y.neg ? lsi_pkg::COORD_MIN : lsi_pkg::COORD_MAX;
        end
        else
        begin
            vy = last.y.neg ? -qy : qy;
        end
        if (last.found)
        begin
            tdata_next = {vy, vx};
            tuser_next = {satx || saty, 1'b1};
        end
        else
        begin
            tdata_next = '0;
            tuser_next = 2'b00;
        end
    end

    assign out_en = !out_valid_reg || m_tready;
    assign chain_ready[lsi_pkg::NUM_CELLS] = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= chain_valid[lsi_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    a_ovf_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("overflow set on a result without a hit");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss carries a nonzero point");

    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:0] == lsi_pkg::COORD_MAX || m_tdata[31:0] == lsi_pkg::COORD_MIN ||
            m_tdata[63:32] == lsi_pkg::COORD_MAX || m_tdata[63:32] == lsi_pkg::COORD_MIN)
        else $error("overflow without a clamped coordinate");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && chain_valid[lsi_pkg::NUM_CELLS])
        else $error("input stalled while the pipeline still has room");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_segment_intersect_top: line pairs are streamed
// with random gaps and back-pressure, each result is checked against an exact
// wide-integer prediction of the crossing point, under several tolerance
// settings including both extremes.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [lsi_pkg::ITEM_W-1:0]  coords;
        logic                        bounded;
    } pair_t;

    typedef struct {
        logic                        found;
        logic [lsi_pkg::COORD_W-1:0] px;
        logic [lsi_pkg::COORD_W-1:0] py;
        logic                        ovf;
    } hit_t;

    // indexes with no register behind them
    localparam logic [lsi_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [lsi_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [lsi_pkg::COORD_W-1:0]   ONE = 32'h0001_0000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lsi_pkg::ITEM_W-1:0]      s_tdata = '0;
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [2*lsi_pkg::COORD_W-1:0]   m_tdata;
    logic [1:0]                      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lsi_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [lsi_pkg::PTOL_W-1:0]      cfg_data = '0;

    pair_t pending_pairs[$];
    hit_t  expected_hits[$];
    logic [lsi_pkg::PTOL_W-1:0] cur_parallel_tol = '0;
    logic [lsi_pkg::TOL_W-1:0]  cur_param_tol = '0;
    bit    pair_taken = 1'b0;
    bit    calm_mode = 1'b0;
    int    hold_left = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    mismatches = 0;

    line_segment_intersect_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact crossing point: all intermediates held in 256-bit signed
    function automatic hit_t predict_crossing(pair_t p);
        logic signed [255:0] c[8];
        logic signed [255:0] rx, ry, sx, sy, qx, qy, den, nt, nu, adn, lo, hi, pt, t;
        logic signed [255:0] cmax, cmin;
        hit_t h;
        h = '{1'b0, '0, '0, 1'b0};
        for (int k = 0; k < 8; k++)
            c[k] = $signed(p.coords[lsi_pkg::COORD_W*k +: lsi_pkg::COORD_W]);
        rx = c[2] - c[0];  ry = c[3] - c[1];
        sx = c[6] - c[4];  sy = c[7] - c[5];
        qx = c[4] - c[0];  qy = c[5] - c[1];
        den = rx * sy - ry * sx;
        nt  = qx * sy - qy * sx;
        nu  = qx * ry - qy * rx;
        adn = (den < 0) ? -den : den;
        if (adn <= $signed({224'd0, cur_parallel_tol}))
            return h;
        if (den < 0)
        begin
            den = -den;
            nt = -nt;
            nu = -nu;
        end
        t  = $signed({240'd0, cur_param_tol});
        lo = -(t * den);
        hi = (t + 65536) * den;
        if (p.bounded && (nt * 65536 < lo || nt * 65536 > hi || nu * 65536 < lo ||
                          nu * 65536 > hi))
            return h;
        h.found = 1'b1;
        cmax = $signed(lsi_pkg::COORD_MAX);
        cmin = $signed(lsi_pkg::COORD_MIN);
        for (int k = 0; k < 2; k++)
        begin
            pt = ((k == 0 ? c[0] : c[1]) * den + (k == 0 ? rx : ry) * nt) / den;
            if (pt > cmax)
            begin
                pt = cmax;
                h.ovf = 1'b1;
            end
            else if (pt < cmin)
            begin
                pt = cmin;
                h.ovf = 1'b1;
            end
            if (k == 0)
                h.px = pt[lsi_pkg::COORD_W-1:0];
            else
                h.py = pt[lsi_pkg::COORD_W-1:0];
        end
        return h;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input side: beat accepted at the rising edge
    always @(posedge clk)
    begin
        pair_taken = 1'b0;
        if (s_tvalid && s_tready)
        begin
            expected_hits = {expected_hits, predict_crossing(pending_pairs[0])};
            void'(pending_pairs.pop_front());
            pair_taken = 1'b1;
        end
        if ($urandom_range(0, 299) == 0)
            calm_mode = !calm_mode;
    end

    always @(negedge clk)
    begin
        if (!(s_tvalid && !pair_taken))
        begin
            if (send_gap > 0 || pending_pairs.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pairs[0].coords;
                s_tuser  <= pending_pairs[0].bounded;
                send_gap = pick_gap();
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        hit_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tdata=%h tuser=%b", m_tdata, m_tuser);
            end
            else
            begin
                e = expected_hits.pop_front();
                if (m_tuser[0] !== e.found || m_tdata[lsi_pkg::COORD_W-1:0] !== e.px ||
                    m_tdata[2*lsi_pkg::COORD_W-1:lsi_pkg::COORD_W] !== e.py ||
                    m_tuser[1] !== e.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp found=%b x=%h y=%h ovf=%b, ",
                                  "got found=%b x=%h y=%h ovf=%b"},
                                 e.found, e.px, e.py, e.ovf, m_tuser[0],
                                 m_tdata[lsi_pkg::COORD_W-1:0],
                                 m_tdata[2*lsi_pkg::COORD_W-1:lsi_pkg::COORD_W], m_tuser[1]);
                end
            end
        end
    end

    task automatic write_reg(logic [lsi_pkg::CFG_IDX_W-1:0] idx,
                             logic [lsi_pkg::PTOL_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lsi_pkg::REG_PARALLEL_TOL)
            cur_parallel_tol = val;
        else if (idx == lsi_pkg::REG_PARAM_TOL)
            cur_param_tol = val[lsi_pkg::TOL_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_pair(logic [lsi_pkg::COORD_W-1:0] ax1, logic [lsi_pkg::COORD_W-1:0] ay1,
                            logic [lsi_pkg::COORD_W-1:0] ax2, logic [lsi_pkg::COORD_W-1:0] ay2,
                            logic [lsi_pkg::COORD_W-1:0] bx1, logic [lsi_pkg::COORD_W-1:0] by1,
                            logic [lsi_pkg::COORD_W-1:0] bx2, logic [lsi_pkg::COORD_W-1:0] by2,
                            logic bnd);
        pair_t p;
        p.coords  = {by2, bx2, by1, bx1, ay2, ax2, ay1, ax1};
        p.bounded = bnd;
        pending_pairs = {pending_pairs, p};
    endtask

    function automatic logic [lsi_pkg::COORD_W-1:0] rand_coord(int kind);
        if (kind == 0)
            return $urandom;
        if (kind == 1)
            return ($urandom_range(0, 16) - 8) <<< 16;
        return (($urandom_range(0, 2000) - 1000) <<< 16) + $urandom_range(0, 65535);
    endfunction

    task automatic add_random(int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            kind = (kind < 2) ? 0 : (kind < 6) ? 1 : 2;
            add_pair(rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
                     rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
                     $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && expected_hits.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed shapes, reset tolerances
        add_pair('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);                  // all degenerate
        add_pair('0, '0, 2*ONE, 2*ONE, '0, 2*ONE, 2*ONE, '0, 1'b1);     // plain cross
        add_pair('0, '0, 2*ONE, 2*ONE, '0, 2*ONE, 2*ONE, '0, 1'b0);
        add_pair('0, '0, ONE, '0, '0, ONE, ONE, ONE, 1'b0);             // parallel
        add_pair('0, '0, ONE, '0, 3*ONE, -ONE, 3*ONE, ONE, 1'b1);       // miss beyond end
        add_pair('0, '0, ONE, '0, 3*ONE, -ONE, 3*ONE, ONE, 1'b0);       // same, infinite
        add_pair('0, '0, ONE, '0, ONE, -ONE, ONE, ONE, 1'b1);           // touch at t = 1
        add_pair('0, '0, ONE, '0, '0, '0, '0, ONE, 1'b1);               // touch at t = 0
        add_pair('0, '0, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1);           // second degenerate
        add_pair(lsi_pkg::COORD_MIN, lsi_pkg::COORD_MIN, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX,
                 lsi_pkg::COORD_MIN, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MIN,
                 1'b1);                                                  // full range
        add_pair(lsi_pkg::COORD_MIN, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MIN,
                 lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MIN, lsi_pkg::COORD_MIN,
                 1'b0);
        add_pair('0, '0, ONE, '0, '0, 1, ONE, 2, 1'b0);                 // near parallel, meets at x = -1
        add_pair('0, '0, -ONE, '0, '0, 1, -ONE, 2, 1'b0);               // mirrored, meets at x = 1
        add_pair('0, '0, 3, 7, 5, -2, 1, 9, 1'b0);                      // tiny, truncation
        add_pair(-5, 3, 7, -11, 2, 2, -9, -4, 1'b0);
        add_pair('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        drain();

        // widest tolerances: lines with |r x s| below 2^32 count as parallel
        write_reg(lsi_pkg::REG_PARALLEL_TOL, '1);
        write_reg(lsi_pkg::REG_PARAM_TOL, 16'hffff);
        add_pair('0, '0, ONE, '0, 3*ONE / 2, -ONE, 3*ONE / 2, ONE, 1'b1);
        add_pair(lsi_pkg::COORD_MIN, lsi_pkg::COORD_MIN, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX,
                 lsi_pkg::COORD_MIN, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MAX, lsi_pkg::COORD_MIN,
                 1'b1);
        add_random(120);
        drain();

        // middle settings, plus writes to unused indexes that must be dropped
        write_reg(lsi_pkg::REG_PARALLEL_TOL, 32'd1000);
        write_reg(lsi_pkg::REG_PARAM_TOL, 16'd4096);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        add_pair('0, '0, ONE, '0, ONE + ONE / 32, -ONE, ONE + ONE / 32, ONE, 1'b1);
        add_random(180);
        drain();

        // back to zero tolerance, long receiver hold-off while input keeps coming
        write_reg(lsi_pkg::REG_PARALLEL_TOL, '0);
        write_reg(lsi_pkg::REG_PARAM_TOL, '0);
        add_random(350);
        hold_left = 400;
        drain();

        if (expected_hits.size() == 0 && mismatches == 0)
            $display("[line_segment_intersect_top] OK");
        else
            $display("[line_segment_intersect_top] ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[line_segment_intersect_top] ERROR");
        $finish;
    end

endmodule

/* line_segment_intersect_top.f */
sv/lsi_pkg.sv
sv/lsi_front.sv
sv/lsi_div_cell.sv
sv/line_segment_intersect_top.sv
tb/tb_top.sv
